>>> src/kvi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyframe vertex interpolator package
// Sizes of the keyframe store, field widths, register codes and the types
// shared by the top level and the vertex store.
// ----------------------------------------------------------------------------
package kvi_pkg;

    localparam int MAX_VERTICES = 512;
    localparam int MAX_FRAMES   = 32;
    localparam int STORE_DEPTH  = MAX_VERTICES * MAX_FRAMES;
    localparam int ADDR_W       = $clog2(STORE_DEPTH);

    localparam int FC_W      = $clog2(MAX_FRAMES + 1);
    localparam int NUM_LANES = 5;
    localparam int COMP_W    = 32;
    localparam int FRAC_W    = 16;
    localparam int VC_W      = 10;
    localparam int FCNT_W    = 6;
    localparam int CFG_W     = 10;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT  = 1'd1;

    typedef logic [NUM_LANES-1:0][COMP_W-1:0] vertex_t;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [ADDR_W-1:0] waddr;
        logic [ADDR_W-1:0] raddr_a;
        logic [ADDR_W-1:0] raddr_b;
    } store_ctl_t;

endpackage

>>> src/kvi_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyframe vertex store
// One write port and two registered read ports over all five components of
// every stored vertex. The read data holds while the read enable is low.
// ----------------------------------------------------------------------------
module kvi_store (
    input  logic                clk,
    input  kvi_pkg::store_ctl_t ctl,
    input  kvi_pkg::vertex_t    wdata,
    output kvi_pkg::vertex_t    rdata_a,
    output kvi_pkg::vertex_t    rdata_b
);
    import kvi_pkg::*;

    vertex_t mem [STORE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            mem[ctl.waddr] <= wdata;
        end
        if (ctl.re)
        begin
            rdata_a <= mem[ctl.raddr_a];
            rdata_b <= mem[ctl.raddr_b];
        end
    end

endmodule

>>> src/keyframe_vertex_interpolator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyframe vertex interpolator
// Stores keyframe vertices and returns one vertex blended linearly between
// two neighboring keyframes for each draw transaction.
//
//   Channel   Handshake               Direction   Payload
//   in        in_valid / in_ready     input       action, load_frame, ...
//   out       out_valid / out_ready   output      out_x .. out_v, bad_index
//   cfg       cfg_write               input       cfg_index, cfg_data
//
// One transaction is accepted per cycle while in_ready is high. A load writes
// the store when it leaves the second stage, in order with the draws around
// it.
// Every stage has a valid bit and moves when the stage after it is empty or
// moving, so a stall at the output fills the bubbles before it blocks input.
// Reset clears the valid bits and sets both counts to one; the store is not
// cleared.
// ----------------------------------------------------------------------------
module keyframe_vertex_interpolator (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                cfg_write,
    input  logic [kvi_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [kvi_pkg::CFG_W-1:0]           cfg_data,

    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                action,
    input  logic [4:0]                          load_frame,
    input  logic [8:0]                          vertex_index,
    input  logic [30:0]                         frame_pos,
    input  logic signed [31:0]                  pos_x,
    input  logic signed [31:0]                  pos_y,
    input  logic signed [31:0]                  pos_z,
    input  logic signed [31:0]                  tex_u,
    input  logic signed [31:0]                  tex_v,

    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [31:0]                  out_x,
    output logic signed [31:0]                  out_y,
    output logic signed [31:0]                  out_z,
    output logic signed [31:0]                  out_u,
    output logic signed [31:0]                  out_v,
    output logic                                bad_index
);
    import kvi_pkg::*;

    localparam int LANE_X = 0;
    localparam int LANE_Y = 1;
    localparam int LANE_Z = 2;
    localparam int LANE_U = 3;
    localparam int LANE_V = 4;

    // Performs up to eight restoring remainder steps, most significant bit
    // first.
    function automatic logic [FC_W-1:0] mod_steps(
        input logic [FC_W-1:0] r_in,
        input logic [7:0]      bits,
        input logic [FC_W-1:0] fc,
        input int              nbits
    );
        logic [FC_W-1:0] r;
        logic [FC_W:0]   t;
        r = r_in;
        for (int i = 7; i >= 0; i--)
        begin
            if (i < nbits)
            begin
                t = {r, bits[i]};
                if (t >= {1'b0, fc})
                begin
                    t = t - {1'b0, fc};
                end
                r = t[FC_W-1:0];
            end
        end
        return r;
    endfunction

    logic [VC_W-1:0]   vertex_count_reg;
    logic [FCNT_W-1:0] frames_used_reg;
    logic [FC_W-1:0]   fc_eff;

    logic en1, en2, en3, en4, en5, en6;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;

    // Stage 1
    logic            act1_reg, ldok1_reg, bad1_reg;
    logic [8:0]      vidx1_reg;
    logic [4:0]      lframe1_reg;
    logic [22:0]     pos1_reg;
    logic [FC_W-1:0] rem1_reg;
    vertex_t         data1_reg;
    logic            bad1_next, ldok1_next;
    logic [FC_W-1:0] rem1_next;

    // Stage 2
    logic              act2_reg, ldok2_reg, bad2_reg;
    logic [8:0]        vidx2_reg;
    logic [4:0]        lframe2_reg;
    logic [FRAC_W-1:0] f2_reg;
    logic [FC_W-1:0]   fa2_reg, fb2_reg;
    vertex_t           data2_reg;
    logic [FC_W-1:0]   fa2_next, fb2_next;
    logic [FC_W:0]     fa_inc;

    // Stage 3
    logic              bad3_reg;
    logic [FRAC_W-1:0] f3_reg;
    store_ctl_t        store_ctl;
    vertex_t           rd_a, rd_b;

    // Stages 4 to 6
    logic              bad4_reg, bad5_reg, bad6_reg;
    logic [FRAC_W-1:0] f4_reg;
    logic signed [COMP_W:0]     diff4_reg [NUM_LANES];
    logic [COMP_W-1:0]          a4_reg    [NUM_LANES];
    logic [COMP_W-1:0]          a5_reg    [NUM_LANES];
    logic [COMP_W-1:0]          part5_reg [NUM_LANES];
    logic [COMP_W-1:0]          out_reg   [NUM_LANES];
    logic signed [2*COMP_W-15:0] prod_next [NUM_LANES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= VC_W'(1);
            frames_used_reg  <= FCNT_W'(1);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_VERTEX_COUNT: vertex_count_reg <= cfg_data[VC_W-1:0];
                REG_FRAME_COUNT:  frames_used_reg  <= cfg_data[FCNT_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        if (frames_used_reg == '0)
        begin
            fc_eff = FC_W'(1);
        end
        else if (int'(frames_used_reg) > MAX_FRAMES)
        begin
            fc_eff = FC_W'(MAX_FRAMES);
        end
        else
        begin
            fc_eff = FC_W'(frames_used_reg);
        end
    end

    assign en6      = !v6_reg || out_ready;
    assign en5      = !v5_reg || en6;
    assign en4      = !v4_reg || en5;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= in_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg && act2_reg;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
            if (en5)
            begin
                v5_reg <= v4_reg;
            end
            if (en6)
            begin
                v6_reg <= v5_reg;
            end
        end
    end

    // The first eight bits of the whole frame number are reduced here.
    assign bad1_next  = ({1'b0, vertex_index} >= vertex_count_reg)
                        || (int'(vertex_index) >= MAX_VERTICES);
    assign ldok1_next = (int'(load_frame) < MAX_FRAMES)
                        && (int'(vertex_index) < MAX_VERTICES);
    assign rem1_next  = mod_steps('0, frame_pos[30:23], fc_eff, 8);

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            act1_reg    <= action;
            ldok1_reg   <= ldok1_next;
            bad1_reg    <= bad1_next;
            vidx1_reg   <= vertex_index;
            lframe1_reg <= load_frame;
            pos1_reg    <= frame_pos[22:0];
            rem1_reg    <= rem1_next;
            data1_reg   <= {tex_v, tex_u, pos_z, pos_y, pos_x};
        end
    end

    // The remaining seven bits give frame A; frame B is the next frame,
    // wrapping to zero, unless the position sits exactly on a frame.
    always_comb
    begin
        fa2_next = mod_steps(rem1_reg, {1'b0, pos1_reg[22:16]}, fc_eff, 7);
        fa_inc   = (FC_W + 1)'(fa2_next) + (FC_W + 1)'(1);
        if (pos1_reg[FRAC_W-1:0] == '0)
        begin
            fb2_next = fa2_next;
        end
        else if (fa_inc == {1'b0, fc_eff})
        begin
            fb2_next = '0;
        end
        else
        begin
            fb2_next = fa_inc[FC_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            act2_reg    <= act1_reg;
            ldok2_reg   <= ldok1_reg;
            bad2_reg    <= bad1_reg;
            vidx2_reg   <= vidx1_reg;
            lframe2_reg <= lframe1_reg;
            f2_reg      <= pos1_reg[FRAC_W-1:0];
            fa2_reg     <= fa2_next;
            fb2_reg     <= fb2_next;
            data2_reg   <= data1_reg;
        end
    end

    always_comb
    begin
        store_ctl.we      = en3 && v2_reg && !act2_reg && ldok2_reg;
        store_ctl.re      = en3 && v2_reg && act2_reg;
        store_ctl.waddr   = ADDR_W'(lframe2_reg) * ADDR_W'(MAX_VERTICES)
                            + ADDR_W'(vidx2_reg);
        store_ctl.raddr_a = ADDR_W'(fa2_reg) * ADDR_W'(MAX_VERTICES)
                            + ADDR_W'(vidx2_reg);
        store_ctl.raddr_b = ADDR_W'(fb2_reg) * ADDR_W'(MAX_VERTICES)
                            + ADDR_W'(vidx2_reg);
    end

    kvi_store u_store (
        .clk     (clk),
        .ctl     (store_ctl),
        .wdata   (data2_reg),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            bad3_reg <= bad2_reg;
            f3_reg   <= f2_reg;
        end
    end

    // Each component is a + ((b - a) * f) >>> 16, kept to 32 bits.
    always_comb
    begin
        for (int i = 0; i < NUM_LANES; i++)
        begin
            prod_next[i] = diff4_reg[i] * $signed({1'b0, f4_reg});
        end
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            bad4_reg <= bad3_reg;
            f4_reg   <= f3_reg;
            for (int i = 0; i < NUM_LANES; i++)
            begin
                a4_reg[i]    <= rd_a[i];
                diff4_reg[i] <= $signed({rd_b[i][COMP_W-1], rd_b[i]})
                                - $signed({rd_a[i][COMP_W-1], rd_a[i]});
            end
        end
        if (en5)
        begin
            bad5_reg <= bad4_reg;
            for (int i = 0; i < NUM_LANES; i++)
            begin
                a5_reg[i]    <= a4_reg[i];
                part5_reg[i] <= prod_next[i][COMP_W+FRAC_W-1:FRAC_W];
            end
        end
        if (en6)
        begin
            bad6_reg <= bad5_reg;
            for (int i = 0; i < NUM_LANES; i++)
            begin
                out_reg[i] <= bad5_reg ? '0 : a5_reg[i] + part5_reg[i];
            end
        end
    end

    assign out_valid = v6_reg;
    assign bad_index = bad6_reg;
    assign out_x     = $signed(out_reg[LANE_X]);
    assign out_y     = $signed(out_reg[LANE_Y]);
    assign out_z     = $signed(out_reg[LANE_Z]);
    assign out_u     = $signed(out_reg[LANE_U]);
    assign out_v     = $signed(out_reg[LANE_V]);

    a_frame_a_range: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg |-> fa2_reg < fc_eff)
        else $error("Frame A is not below the frame count.");

    a_frame_b_range: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg |-> fb2_reg < fc_eff)
        else $error("Frame B is not below the frame count.");

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_index |-> out_x == 0 && out_y == 0 && out_z == 0
                                   && out_u == 0 && out_v == 0)
        else $error("A bad index transaction carries nonzero components.");

    a_stall_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        v5_reg && v6_reg && !out_ready |=> v5_reg && v6_reg)
        else $error("An item was dropped while the output stalled.");

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        store_ctl.we |-> !store_ctl.re && !act2_reg)
        else $error("The store was written by a draw transaction.");

endmodule
